// ===== rtl/core/pic_pkg.sv =====
// Shared types and codes for the priority interrupt controller.
package pic_pkg;

  localparam logic [2:0] CMD_WRITE  = 3'd0;
  localparam logic [2:0] CMD_PERIPH = 3'd1;
  localparam logic [2:0] CMD_CORE   = 3'd2;
  localparam logic [2:0] CMD_ENTRY  = 3'd3;
  localparam logic [2:0] CMD_RETURN = 3'd4;

  localparam int BIT_GIEH = 7;
  localparam int BIT_GIEL = 6;

  localparam logic [1:0] REG_PRIORITY_ENABLE = 2'd0;
  localparam logic [1:0] REG_TIMER_HIGH      = 2'd1;
  localparam logic [1:0] REG_PORT_HIGH       = 2'd2;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] write_value;
    logic       event_high;
    logic [1:0] periph_pending;
  } evt_beat_t;

  typedef struct packed {
    logic [7:0] control_value;
    logic       irq_request;
    logic       vector_low;
  } res_beat_t;

endpackage

// ===== rtl/core/pic_evt_if.sv =====
// Event channel: valid/ready handshake carrying one event beat.
interface pic_evt_if import pic_pkg::*; ();
  logic      valid;
  logic      ready;
  evt_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/pic_res_if.sv =====
// Result channel: valid/ready handshake carrying one result beat.
interface pic_res_if import pic_pkg::*; ();
  logic      valid;
  logic      ready;
  res_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/priority_interrupt_controller.sv =====
// The result beat for an accepted event beat is registered and appears in the next cycle.
// Throughput: one event beat per cycle while the result beat is taken; the result register frees when taken.
// The event logic is a few gates between the state registers and the result register.
// Reset (synchronous, rst high): control register 0, high vector, priority mode off,
// timer and port change sources high priority, no result pending.
module priority_interrupt_controller import pic_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  pic_evt_if.sink     evt,
  pic_res_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       priority_enable;
  logic       timer_high;
  logic       port_high;
  logic [7:0] control_reg;
  logic       vector_sel;
  logic       res_valid;
  res_beat_t  res_beat;

  logic [7:0] control_next;
  logic       vector_next;
  logic       irq_next;
  logic [7:0] reg_mod;
  logic [2:0] armed;
  logic [2:0] hi_mask;
  logic [2:0] lo_mask;
  logic       eval_req;
  logic       eval_vec;
  logic       eval_hold;
  logic       evt_fire;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      REG_PRIORITY_ENABLE: prdata = {31'd0, priority_enable};
      REG_TIMER_HIGH:      prdata = {31'd0, timer_high};
      REG_PORT_HIGH:       prdata = {31'd0, port_high};
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      priority_enable <= 1'b0;
      timer_high      <= 1'b1;
      port_high       <= 1'b1;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_PRIORITY_ENABLE: priority_enable <= pwdata[0];
        REG_TIMER_HIGH:      timer_high      <= pwdata[0];
        REG_PORT_HIGH:       port_high       <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign evt.ready = !res_valid || res.ready;
  assign evt_fire  = evt.valid && evt.ready;

  always_comb begin
    reg_mod = control_reg;
    case (evt.payload.cmd)
      CMD_WRITE: reg_mod = evt.payload.write_value;
      CMD_ENTRY: begin
        if (!priority_enable || !vector_sel) begin
          reg_mod[BIT_GIEH] = 1'b0;
        end else begin
          reg_mod[BIT_GIEL] = 1'b0;
        end
      end
      CMD_RETURN: begin
        if (priority_enable && control_reg[BIT_GIEH]) begin
          reg_mod[BIT_GIEL] = 1'b1;
        end else begin
          reg_mod[BIT_GIEH] = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    armed     = reg_mod[5:3] & reg_mod[2:0];
    hi_mask   = {timer_high, 1'b1, port_high};
    lo_mask   = {~timer_high, 1'b0, ~port_high};
    eval_req  = 1'b0;
    eval_vec  = 1'b0;
    eval_hold = 1'b0;
    if (priority_enable) begin
      if (!reg_mod[BIT_GIEH]) begin
        eval_hold = 1'b1;
      end else if ((|(armed & hi_mask)) || evt.payload.periph_pending[1]) begin
        eval_req = 1'b1;
      end else if (((|(armed & lo_mask)) || evt.payload.periph_pending[0])
                   && reg_mod[BIT_GIEL]) begin
        eval_req = 1'b1;
        eval_vec = 1'b1;
      end else begin
        eval_hold = 1'b1;
      end
    end else begin
      eval_req = reg_mod[BIT_GIEH] && ((|armed) ||
                 (reg_mod[BIT_GIEL] && (|evt.payload.periph_pending)));
    end
  end

  always_comb begin
    control_next = control_reg;
    vector_next  = vector_sel;
    irq_next     = 1'b0;
    case (evt.payload.cmd)
      CMD_WRITE, CMD_ENTRY, CMD_RETURN: begin
        control_next = reg_mod;
        irq_next     = eval_req;
        vector_next  = eval_hold ? vector_sel : eval_vec;
      end
      CMD_PERIPH, CMD_CORE: begin
        if (!priority_enable && evt.payload.cmd == CMD_PERIPH) begin
          irq_next = control_reg[BIT_GIEH] && control_reg[BIT_GIEL];
        end else if (evt.payload.event_high || !priority_enable) begin
          if (control_reg[BIT_GIEH]) begin
            irq_next    = 1'b1;
            vector_next = 1'b0;
          end
        end else if (control_reg[BIT_GIEH] && control_reg[BIT_GIEL]) begin
          irq_next    = 1'b1;
          vector_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg <= 8'd0;
      vector_sel  <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (evt_fire) begin
        control_reg <= control_next;
        vector_sel  <= vector_next;
        res_valid   <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt_fire) begin
      res_beat.control_value <= control_next;
      res_beat.irq_request   <= irq_next;
      res_beat.vector_low    <= vector_next;
    end
  end

  assign res.valid   = res_valid;
  assign res.payload = res_beat;

  a_rst_clears: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result pending after reset");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    evt_fire |=> res.valid)
    else $error("accepted beat produced no result");

  a_irq_needs_gieh: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.payload.irq_request) |-> res.payload.control_value[BIT_GIEH])
    else $error("request raised with global enable clear");

  a_state_matches: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.payload.control_value == control_reg
                   && res.payload.vector_low == vector_sel))
    else $error("result register out of step with state");

endmodule
